// File: hw/rtl/rgbdc_pkg.sv
// Package: types and constants shared by the daisy-chain packet node.
`default_nettype none
package rgbdc_pkg;

  localparam int unsigned ByteW = 8;

  typedef logic [ByteW-1:0] byte_t;

  // Packet positions with a fixed role
  localparam byte_t POS_LENGTH    = 8'd0;
  localparam byte_t POS_RED       = 8'd1;
  localparam byte_t POS_GREEN     = 8'd2;
  localparam byte_t POS_BLUE      = 8'd3;
  localparam byte_t FIRST_FORWARD = 8'd4;

  localparam byte_t END_MARK    = 8'h0D;
  localparam byte_t HEADER_DROP = 8'd3;

  typedef struct packed {
    byte_t byte_position;
    byte_t packet_length;
    byte_t red_level;
    byte_t green_level;
    byte_t blue_level;
  } parse_state_t;

  typedef struct packed {
    logic  tx_valid;
    byte_t tx_byte;
    byte_t red_duty;
    byte_t green_duty;
    byte_t blue_duty;
    logic  packet_done;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/rgbdc_in_if.sv
// Interface: input channel, one received byte per beat.
`default_nettype none
interface rgbdc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rgbdc_out_if.sv
// Interface: output channel, one result per beat.
`default_nettype none
interface rgbdc_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [7:0]  red_duty;
  logic [7:0]  green_duty;
  logic [7:0]  blue_duty;
  logic        packet_done;

  modport source (output valid, output tx_valid, output tx_byte, output red_duty,
                  output green_duty, output blue_duty, output packet_done,
                  input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input red_duty,
                  input green_duty, input blue_duty, input packet_done,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rgb_daisy_chain_packet_node.sv
// Top level: daisy-chain LED packet node with registered result.
//
//   channel     dir  payload                                        beat
//   upstream    in   rx_byte[7:0]                                   one received byte
//   downstream  out  tx_valid, tx_byte[7:0], red/green/blue_duty,   one result per
//                    packet_done                                    input byte
//
// One byte per cycle unless downstream stalls; its result appears in the next cycle.
// Parse state updates in the accepting cycle; result register holds one beat.
// upstream.ready is high while the result register is empty or being drained.
// Synchronous reset returns the parser to the length byte with all colour levels at zero.
`default_nettype none
module rgb_daisy_chain_packet_node (
  input  wire logic   clk,
  input  wire logic   rst,
  rgbdc_in_if.sink    upstream,
  rgbdc_out_if.source downstream
);
  import rgbdc_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  result_t      step_result;
  result_t      out_data;
  logic         out_valid;
  logic         accept;

  rgbdc_parser u_parser (
    .state      (state),
    .rx_byte    (upstream.rx_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  assign upstream.ready = !out_valid || downstream.ready;
  assign accept         = upstream.valid && upstream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upstream.ready) begin
      out_valid <= upstream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= step_result;
    end
  end

  assign downstream.valid       = out_valid;
  assign downstream.tx_valid    = out_data.tx_valid;
  assign downstream.tx_byte     = out_data.tx_byte;
  assign downstream.red_duty    = out_data.red_duty;
  assign downstream.green_duty  = out_data.green_duty;
  assign downstream.blue_duty   = out_data.blue_duty;
  assign downstream.packet_done = out_data.packet_done;

endmodule
`default_nettype wire

// File: hw/rtl/rgbdc_parser.sv
// Parser step: next parse state and result for one received byte.
`default_nettype none
module rgbdc_parser (
  input  rgbdc_pkg::parse_state_t state,
  input  rgbdc_pkg::byte_t        rx_byte,
  output rgbdc_pkg::parse_state_t state_next,
  output rgbdc_pkg::result_t      result
);
  import rgbdc_pkg::*;

  byte_t pos;
  byte_t last;
  logic  done;
  logic  valid;
  byte_t tx;

  assign pos = state.byte_position;

  always_comb begin
    state_next = state;
    valid      = 1'b0;
    tx         = '0;
    priority if (pos == POS_LENGTH) begin
      state_next.packet_length = rx_byte;
    end else if (pos == POS_RED) begin
      state_next.red_level = rx_byte;
    end else if (pos == POS_GREEN) begin
      state_next.green_level = rx_byte;
    end else if (pos == POS_BLUE) begin
      state_next.blue_level = rx_byte;
      tx    = state.packet_length - HEADER_DROP;
      valid = 1'b1;
    end else begin
    end

    last = state_next.packet_length - 8'd1;
    done = (pos == last);

    if (pos >= FIRST_FORWARD) begin
      valid = 1'b1;
      tx    = done ? END_MARK : rx_byte;
    end

    state_next.byte_position = done ? POS_LENGTH : pos + 8'd1;
  end

  always_comb begin
    result.tx_valid    = valid;
    result.tx_byte     = tx;
    result.red_duty    = state_next.red_level;
    result.green_duty  = state_next.green_level;
    result.blue_duty   = state_next.blue_level;
    result.packet_done = done;
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgbdc_checker.sv
// Checker: port-level assertions for the packet node, bound to the top level.
`default_nettype none
module rgbdc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       tx_valid,
  input wire logic [7:0] tx_byte,
  input wire logic       packet_done
);
  import rgbdc_pkg::*;

  // Every accepted byte shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(tx_valid))
    else $error("stalled result changed");

  a_quiet_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("tx_byte nonzero without tx_valid");

  // A sent byte that ends a packet is the end mark or a length-4 header
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid && packet_done |-> tx_byte == END_MARK || tx_byte == 8'h01)
    else $error("bad byte at packet end");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind rgb_daisy_chain_packet_node rgbdc_checker u_rgbdc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (upstream.valid),
  .in_ready    (upstream.ready),
  .out_valid   (downstream.valid),
  .out_ready   (downstream.ready),
  .tx_valid    (downstream.tx_valid),
  .tx_byte     (downstream.tx_byte),
  .packet_done (downstream.packet_done)
);
`default_nettype wire
